/* design/hb_pkg.sv */
package hb_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic REG_HEAP_ORDER = 1'b0;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      is_last_res;
    } t_res;

endpackage

/* design/hb_mem.sv */
module hb_mem #(
    parameter int DEPTH = hb_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic signed [hb_pkg::VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]                    i_raddr_a,
    input  logic [AW-1:0]                    i_raddr_b,
    output logic signed [hb_pkg::VALUE_W-1:0] o_rdata_a,
    output logic signed [hb_pkg::VALUE_W-1:0] o_rdata_b
);

    logic signed [hb_pkg::VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* design/hb_ctrl.sv */
module hb_ctrl #(
    parameter int DEPTH = hb_pkg::DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  hb_pkg::t_req i_req,
    input  logic         i_min_mode,
    output logic         o_res_strobe,
    output hb_pkg::t_res o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 1;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_FETCH = 7'b0000010,
        ST_HOLD  = 7'b0000100,
        ST_KIDS  = 7'b0001000,
        ST_CMP   = 7'b0010000,
        ST_PUT   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_n, n_n;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_k, n_k;
    logic          r_min, n_min;
    logic signed [hb_pkg::VALUE_W-1:0] r_carry, n_carry;
    logic          r_emit_vld, n_emit_vld;
    logic          r_emit_last, n_emit_last;

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [hb_pkg::VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]                     addr_a, addr_b;
    logic signed [hb_pkg::VALUE_W-1:0] rd_a, rd_b;

    logic [XW-1:0] n_ext, left_idx, right_idx, best_idx, best_left;
    logic          right_ok, cl, cr_c, cr_l, pick_r, pick_l, swap;
    logic signed [hb_pkg::VALUE_W-1:0] best_val;
    logic          accept, run_end;

    function automatic logic ranks_above(input logic signed [hb_pkg::VALUE_W-1:0] a,
                                         input logic signed [hb_pkg::VALUE_W-1:0] b,
                                         input logic min_mode);
        ranks_above = min_mode ? (a < b) : (a > b);
    endfunction

    hb_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign n_ext     = XW'(r_n);
    assign left_idx  = {r_pos, 1'b1};
    assign right_idx = left_idx + XW'(1);
    assign right_ok  = right_idx < n_ext;

    // rd_a holds the left child, rd_b the right child
    assign cl     = ranks_above(rd_a, r_carry, r_min);
    assign cr_c   = ranks_above(rd_b, r_carry, r_min);
    assign cr_l   = ranks_above(rd_b, rd_a, r_min);
    assign pick_r = right_ok && (cl ? cr_l : cr_c);
    assign pick_l = cl && !pick_r;
    assign swap   = pick_l || pick_r;
    assign best_idx  = pick_r ? right_idx : left_idx;
    assign best_val  = pick_r ? rd_b : rd_a;
    assign best_left = {best_idx[AW-1:0], 1'b1};

    assign accept  = i_start && (r_state == ST_LOAD);
    assign run_end = i_req.is_last || (r_cnt == CW'(DEPTH - 1));

    always_comb begin
        addr_a = left_idx[AW-1:0];
        unique case (r_state)
            ST_EMIT:  addr_a = r_k;
            ST_FETCH: addr_a = r_i;
            default:  addr_a = left_idx[AW-1:0];
        endcase
    end
    assign addr_b = right_idx[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_i         = r_i;
        n_pos       = r_pos;
        n_k         = r_k;
        n_min       = r_min;
        n_carry     = r_carry;
        n_emit_vld  = 1'b0;
        n_emit_last = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_carry;
        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cnt[AW-1:0];
                    mem_wdata = i_req.value;
                    if (run_end) begin
                        n_cnt = '0;
                        n_n   = r_cnt + CW'(1);
                        n_min = i_min_mode;
                        n_k   = '0;
                        if (r_cnt == '0) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_i     = AW'((r_cnt + CW'(1)) >> 1) - AW'(1);
                            n_state = ST_FETCH;
                        end
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            ST_FETCH: begin
                n_pos   = r_i;
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                n_carry = rd_a;
                n_state = ST_CMP;
            end
            ST_KIDS: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                mem_we = 1'b1;
                if (swap) begin
                    mem_wdata = best_val;
                    n_pos     = best_idx[AW-1:0];
                    n_state   = (best_left < n_ext) ? ST_KIDS : ST_PUT;
                end else if (r_i == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_i     = r_i - AW'(1);
                    n_state = ST_FETCH;
                end
            end
            ST_PUT: begin
                mem_we = 1'b1;
                if (r_i == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_i     = r_i - AW'(1);
                    n_state = ST_FETCH;
                end
            end
            ST_EMIT: begin
                n_emit_vld  = 1'b1;
                n_emit_last = (XW'(r_k) + XW'(1)) == n_ext;
                n_k         = r_k + AW'(1);
                if (n_emit_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_cnt      <= '0;
            r_emit_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_emit_vld <= n_emit_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_i         <= n_i;
        r_pos       <= n_pos;
        r_k         <= n_k;
        r_min       <= n_min;
        r_carry     <= n_carry;
        r_emit_last <= n_emit_last;
    end

    assign o_busy            = (r_state != ST_LOAD);
    assign o_res_strobe      = r_emit_vld;
    assign o_res.value_res   = rd_a;
    assign o_res.is_last_res = r_emit_last;

    a_strobe_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_vld |-> $past(r_state == ST_EMIT))
        else $error("result strobe without a read in emit");

    a_last_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit_vld && r_emit_last) |-> (r_state == ST_LOAD))
        else $error("final result while still working");

    a_cmp_has_child: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (left_idx < n_ext))
        else $error("compare at a node without children");

    a_no_write_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !mem_we)
        else $error("store written while emitting");

    a_load_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_cnt < CW'(DEPTH)))
        else $error("element count past depth");

endmodule

/* design/heap_build_unit.sv */
// channel  | handshake                    | payload
// ---------+------------------------------+----------------------------------
// request  | start in, busy out           | i_req  (value, is_last)
// result   | o_res_strobe out, no stall   | o_res  (value_res, is_last_res)
// config   | apb psel/penable/pwrite      | paddr, pwdata, prdata, pready
//
// loading accepts one request per cycle; busy stays low until the run ends.
// build: each sift goes fetch, hold, compare; a winning child moves up, then kids
// and compare again, or put at a leaf; all on the two-read one-write store.
// reset clears control state only; the store is not cleared.
// results come one per cycle, each in the cycle after its emit read, no stall.
module heap_build_unit #(
    parameter int DEPTH = hb_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  hb_pkg::t_req                 i_req,
    output logic                         o_res_strobe,
    output hb_pkg::t_res                 o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hb_pkg::PADDR_W-1:0]   paddr,
    input  logic [hb_pkg::PDATA_W-1:0]   pwdata,
    output logic [hb_pkg::PDATA_W-1:0]   prdata,
    output logic                         pready
);

    logic r_heap_order;
    logic hit_order;

    assign pready    = 1'b1;
    assign hit_order = (paddr[2] == hb_pkg::REG_HEAP_ORDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_order <= 1'b0;
        end else if (psel && penable && pwrite && hit_order) begin
            r_heap_order <= pwdata[0];
        end
    end

    assign prdata = hit_order ? {{(hb_pkg::PDATA_W-1){1'b0}}, r_heap_order} : '0;

    hb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_req        (i_req),
        .i_min_mode   (r_heap_order),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule
